// File: hw/rtl/lr_pkg.sv
// Shared definitions for the line rasterizer: item kinds, queue sizing and the
// command and flag groups passed between the front and back parts.
// No dependencies.
package lr_pkg;

   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic start;
      logic neg_x;
      logic neg_y;
   } lr_cmd_type;

   typedef struct packed {
      logic pixel_valid;
      logic last;
   } lr_flags_type;

endpackage

// File: hw/rtl/lr_front.sv
// Front part of the line rasterizer: accepts items, classifies them and works
// out step signs and absolute deltas, then holds them in a short queue.
// Depends on lr_pkg.
module lr_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_mode,
   input  logic signed [COORD_BITS-1:0] in_x1,
   input  logic signed [COORD_BITS-1:0] in_y1,
   input  logic signed [COORD_BITS-1:0] in_x2,
   input  logic signed [COORD_BITS-1:0] in_y2,
   output logic                         q_valid,
   input  logic                         q_ready,
   output lr_pkg::lr_cmd_type           q_cmd,
   output logic signed [COORD_BITS-1:0] q_x1,
   output logic signed [COORD_BITS-1:0] q_y1,
   output logic signed [COORD_BITS-1:0] q_x2,
   output logic signed [COORD_BITS-1:0] q_y2,
   output logic        [COORD_BITS-1:0] q_dx,
   output logic        [COORD_BITS-1:0] q_dy
);

   localparam int ENTRY_BITS = 6 * COORD_BITS;

   logic [COORD_BITS:0] dx_full;
   logic [COORD_BITS:0] dy_full;
   logic [ENTRY_BITS-1:0] entry_in;
   lr_pkg::lr_cmd_type cmd_in;
   logic push;
   logic pop;

   lr_pkg::lr_cmd_type queue_cmd_ff [lr_pkg::QUEUE_DEPTH];
   logic [ENTRY_BITS-1:0] queue_data_ff [lr_pkg::QUEUE_DEPTH];
   logic [ENTRY_BITS-1:0] head_data;

   logic [lr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lr_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign dx_full = (in_x2 > in_x1) ? ({in_x2[COORD_BITS-1], in_x2} - {in_x1[COORD_BITS-1], in_x1})
                                    : ({in_x1[COORD_BITS-1], in_x1} - {in_x2[COORD_BITS-1], in_x2});
   assign dy_full = (in_y2 > in_y1) ? ({in_y2[COORD_BITS-1], in_y2} - {in_y1[COORD_BITS-1], in_y1})
                                    : ({in_y1[COORD_BITS-1], in_y1} - {in_y2[COORD_BITS-1], in_y2});

   always_comb begin
      cmd_in.start = (in_mode == lr_pkg::MODE_START);
      cmd_in.neg_x = !(in_x1 < in_x2);
      cmd_in.neg_y = !(in_y1 < in_y2);
      entry_in = {dy_full[COORD_BITS-1:0], dx_full[COORD_BITS-1:0], in_y2, in_x2, in_y1, in_x1};
   end

   assign in_ready = (count_ff != lr_pkg::QUEUE_CNT_BITS'(lr_pkg::QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == lr_pkg::QUEUE_PTR_BITS'(lr_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == lr_pkg::QUEUE_PTR_BITS'(lr_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_cmd_ff[wr_ptr_ff]  <= cmd_in;
         queue_data_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head_data = queue_data_ff[rd_ptr_ff];
   assign q_cmd     = queue_cmd_ff[rd_ptr_ff];
   assign q_x1      = head_data[0*COORD_BITS +: COORD_BITS];
   assign q_y1      = head_data[1*COORD_BITS +: COORD_BITS];
   assign q_x2      = head_data[2*COORD_BITS +: COORD_BITS];
   assign q_y2      = head_data[3*COORD_BITS +: COORD_BITS];
   assign q_dx      = head_data[4*COORD_BITS +: COORD_BITS];
   assign q_dy      = head_data[5*COORD_BITS +: COORD_BITS];

endmodule

// File: hw/rtl/lr_back.sv
// Back part of the line rasterizer: holds the line state, runs one error-term
// step per advance on an active line, and keeps results in an output register.
// Depends on lr_pkg.
module lr_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  lr_pkg::lr_cmd_type    q_cmd,
   input  logic [COORD_BITS-1:0] q_x1,
   input  logic [COORD_BITS-1:0] q_y1,
   input  logic [COORD_BITS-1:0] q_x2,
   input  logic [COORD_BITS-1:0] q_y2,
   input  logic [COORD_BITS-1:0] q_dx,
   input  logic [COORD_BITS-1:0] q_dy,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [COORD_BITS-1:0] out_x,
   output logic [COORD_BITS-1:0] out_y,
   output lr_pkg::lr_flags_type  out_flags
);

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] target_x_ff, target_x_in;
   logic [COORD_BITS-1:0] target_y_ff, target_y_in;
   logic                  neg_x_ff, neg_x_in;
   logic                  neg_y_ff, neg_y_in;
   logic [COORD_BITS-1:0] dx_ff, dx_in;
   logic [COORD_BITS-1:0] dy_ff, dy_in;
   logic [COORD_BITS:0]   err_ff, err_in;
   logic                  active_ff, active_in;

   logic                  out_valid_ff;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in;
   logic [COORD_BITS-1:0] out_y_ff, out_y_in;
   lr_pkg::lr_flags_type  out_flags_ff, out_flags_in;

   logic take;
   logic signed [COORD_BITS+2:0] err_ext;
   logic signed [COORD_BITS+2:0] err2;
   logic signed [COORD_BITS+2:0] dx_s;
   logic signed [COORD_BITS+2:0] dy_s;
   logic signed [COORD_BITS+2:0] err_sum;
   logic step_x;
   logic step_y;
   logic [COORD_BITS-1:0] adv_x;
   logic [COORD_BITS-1:0] adv_y;
   logic start_done;
   logic adv_done;

   assign q_ready = !out_valid_ff || out_ready;
   assign take    = q_valid && q_ready;

   always_comb begin
      err_ext = $signed({{2{err_ff[COORD_BITS]}}, err_ff});
      err2    = $signed({err_ff[COORD_BITS], err_ff, 1'b0});
      dx_s    = $signed({3'b000, dx_ff});
      dy_s    = $signed({3'b000, dy_ff});
      step_x  = (err2 > -dy_s);
      step_y  = (err2 < dx_s);
      err_sum = err_ext - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
      adv_x   = cur_x_ff;
      adv_y   = cur_y_ff;
      if (step_x) begin
         adv_x = neg_x_ff ? cur_x_ff - COORD_BITS'(1) : cur_x_ff + COORD_BITS'(1);
      end
      if (step_y) begin
         adv_y = neg_y_ff ? cur_y_ff - COORD_BITS'(1) : cur_y_ff + COORD_BITS'(1);
      end
      start_done = (q_x1 == q_x2) && (q_y1 == q_y2);
      adv_done   = (adv_x == target_x_ff) && (adv_y == target_y_ff);
   end

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      target_x_in  = target_x_ff;
      target_y_in  = target_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      err_in       = err_ff;
      active_in    = active_ff;
      out_x_in     = '0;
      out_y_in     = '0;
      out_flags_in = '0;
      if (take) begin
         if (q_cmd.start) begin
            cur_x_in     = q_x1;
            cur_y_in     = q_y1;
            target_x_in  = q_x2;
            target_y_in  = q_y2;
            neg_x_in     = q_cmd.neg_x;
            neg_y_in     = q_cmd.neg_y;
            dx_in        = q_dx;
            dy_in        = q_dy;
            err_in       = {1'b0, q_dx} - {1'b0, q_dy};
            active_in    = !start_done;
            out_x_in     = q_x1;
            out_y_in     = q_y1;
            out_flags_in = '{pixel_valid: 1'b1, last: start_done};
         end else if (active_ff) begin
            cur_x_in     = adv_x;
            cur_y_in     = adv_y;
            err_in       = err_sum[COORD_BITS:0];
            active_in    = !adv_done;
            out_x_in     = adv_x;
            out_y_in     = adv_y;
            out_flags_in = '{pixel_valid: 1'b1, last: adv_done};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         if (take) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      target_x_ff <= target_x_in;
      target_y_ff <= target_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      err_ff      <= err_in;
      if (take) begin
         out_x_ff     <= out_x_in;
         out_y_ff     <= out_y_in;
         out_flags_ff <= out_flags_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_flags = out_flags_ff;

   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      take && !q_cmd.start && !active_ff |=>
         out_valid_ff && !out_flags_ff.pixel_valid && !out_flags_ff.last &&
         (out_x_ff == '0) && (out_y_ff == '0))
      else $error("Advance without an active line did not give an empty result.");

   a_last_is_pixel: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_flags_ff.last |-> out_flags_ff.pixel_valid)
      else $error("Endpoint flag set on a result without a pixel.");

   a_idle_stays: assert property (@(posedge clock) disable iff (reset)
      take && !q_cmd.start && !active_ff |=> !active_ff)
      else $error("Advance without an active line started a line.");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      take && out_flags_in.last |=> !active_ff)
      else $error("Line stayed active after its endpoint.");

endmodule

// File: hw/rtl/line_rasterizer_unit.sv
// Bresenham line rasterizer: a start item loads two endpoints and gives the first
// pixel, and each advance item gives the next pixel, with the endpoint marked by
// rsp_tlast; an advance with no active line gives a result with rsp_tuser low. One
// item is taken and one result leaves per clock while rsp_tready is high; the rate is
// set by the error-term step of the back part. A two-entry queue and an output
// register absorb stalls; an output stall drops req_tready only once the queue fills.
// Depends on lr_pkg, lr_front and lr_back.
module line_rasterizer_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: start_x, start_y, end_x, end_y, zero fill.
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // Field: mode.
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // Fields from bit 0: pixel_x, pixel_y, zero fill.
   output logic [((2*COORD_BITS+7)/8)*8-1:0]        rsp_tdata,
   // Field: pixel_valid.
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int RSP_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

   lr_pkg::lr_cmd_type   q_cmd;
   lr_pkg::lr_flags_type out_flags;
   logic                  q_valid;
   logic                  q_ready;
   logic [COORD_BITS-1:0] q_x1;
   logic [COORD_BITS-1:0] q_y1;
   logic [COORD_BITS-1:0] q_x2;
   logic [COORD_BITS-1:0] q_y2;
   logic [COORD_BITS-1:0] q_dx;
   logic [COORD_BITS-1:0] q_dy;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;

   lr_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_mode  (req_tuser),
      .in_x1    (req_tdata[0*COORD_BITS +: COORD_BITS]),
      .in_y1    (req_tdata[1*COORD_BITS +: COORD_BITS]),
      .in_x2    (req_tdata[2*COORD_BITS +: COORD_BITS]),
      .in_y2    (req_tdata[3*COORD_BITS +: COORD_BITS]),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd),
      .q_x1     (q_x1),
      .q_y1     (q_y1),
      .q_x2     (q_x2),
      .q_y2     (q_y2),
      .q_dx     (q_dx),
      .q_dy     (q_dy)
   );

   lr_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_cmd     (q_cmd),
      .q_x1      (q_x1),
      .q_y1      (q_y1),
      .q_x2      (q_x2),
      .q_y2      (q_y2),
      .q_dx      (q_dx),
      .q_dy      (q_dy),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_flags (out_flags)
   );

   assign rsp_tdata = RSP_TDATA_BITS'({out_y, out_x});
   assign rsp_tuser = out_flags.pixel_valid;
   assign rsp_tlast = out_flags.last;

endmodule

// File: dv/line_rasterizer_checker.sv
// Scoreboard for the line rasterizer: watches both streams, steps its own Bresenham
// tracker on every accepted request and compares each accepted pixel with the oldest one owed.
// Depends on lr_pkg.
module line_rasterizer_checker #(
   parameter int COORD_BITS = 12
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   input  logic                                     req_tready,
   // Fields from bit 0: start_x, start_y, end_x, end_y, zero fill.
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // Field: mode.
   input  logic                                     req_tuser,
   input  logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // Fields from bit 0: pixel_x, pixel_y, zero fill.
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]        rsp_tdata,
   // Field: pixel_valid.
   input  logic                                     rsp_tuser,
   input  logic                                     rsp_tlast,
   output int                                       mismatches,
   output int                                       pixels_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_W = ((4*COORD_BITS+7)/8)*8;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] span_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      valid;
      logic      last;
   } pixel_type;

   coord_type              cur_x, cur_y, goal_x, goal_y;
   logic                   neg_x, neg_y;
   span_type               span_x, span_y;
   logic signed [COORD_BITS:0] err_acc;
   logic                   drawing;

   pixel_type pixel_queue[$];
   pixel_type want, got;

   task automatic rasterize_step(input logic mode, input logic [REQ_W-1:0] d,
                                 output pixel_type px);
      int x1, y1, x2, y2, e, e2;
      if (mode != lr_pkg::MODE_START && !drawing) begin
         px = '{x: '0, y: '0, valid: 1'b0, last: 1'b0};
      end else begin
         if (mode == lr_pkg::MODE_START) begin
            x1 = $signed(d[0 +: COORD_BITS]);
            y1 = $signed(d[COORD_BITS +: COORD_BITS]);
            x2 = $signed(d[2*COORD_BITS +: COORD_BITS]);
            y2 = $signed(d[3*COORD_BITS +: COORD_BITS]);
            cur_x  = coord_type'(x1);
            cur_y  = coord_type'(y1);
            goal_x = coord_type'(x2);
            goal_y = coord_type'(y2);
            neg_x  = !(x1 < x2);
            neg_y  = !(y1 < y2);
            span_x = span_type'((x2 > x1) ? x2 - x1 : x1 - x2);
            span_y = span_type'((y2 > y1) ? y2 - y1 : y1 - y2);
            err_acc = (COORD_BITS+1)'(int'(span_x) - int'(span_y));
         end else begin
            e  = err_acc;
            e2 = 2 * e;
            if (e2 > -int'(span_y)) begin
               e = e - int'(span_y);
               cur_x = neg_x ? coord_type'(cur_x - 1) : coord_type'(cur_x + 1);
            end
            if (e2 < int'(span_x)) begin
               e = e + int'(span_x);
               cur_y = neg_y ? coord_type'(cur_y - 1) : coord_type'(cur_y + 1);
            end
            err_acc = (COORD_BITS+1)'(e);
         end
         drawing = !(cur_x == goal_x && cur_y == goal_y);
         px = '{x: cur_x, y: cur_y, valid: 1'b1, last: !drawing};
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_x      = '0;
         cur_y      = '0;
         goal_x     = '0;
         goal_y     = '0;
         neg_x      = 1'b0;
         neg_y      = 1'b0;
         span_x     = '0;
         span_y     = '0;
         err_acc    = '0;
         drawing    = 1'b0;
         mismatches = 0;
         pixel_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{x: rsp_tdata[0 +: COORD_BITS], y: rsp_tdata[COORD_BITS +: COORD_BITS],
                    valid: rsp_tuser, last: rsp_tlast};
            if (pixel_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: pixel transfer with none owed: x=%0d y=%0d valid=%0b last=%0b",
                           $realtime, got.x, got.y, got.valid, got.last);
            end else begin
               want = pixel_queue.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.valid !== want.valid ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: pixel mismatch: expected x=%0d y=%0d valid=%0b last=%0b, %s",
                              $realtime, want.x, want.y, want.valid, want.last,
                              $sformatf("got x=%0d y=%0d valid=%0b last=%0b",
                                        got.x, got.y, got.valid, got.last));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rasterize_step(req_tuser, req_tdata, want);
            pixel_queue.push_back(want);
         end
      end
      pixels_owed = pixel_queue.size();
   end

endmodule

// File: dv/tb_line_rasterizer_unit.sv
// Top of the line rasterizer testbench: drives directed and random line requests in
// bursts, stalls the pixel stream and gives the verdict from the checker's count.
// Depends on lr_pkg, line_rasterizer_unit and line_rasterizer_checker.
module tb_line_rasterizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 12;
   localparam int REQ_W = ((4*COORD_BITS+7)/8)*8;
   localparam int RSP_W = ((2*COORD_BITS+7)/8)*8;
   localparam int COORD_MIN = -(1 << (COORD_BITS-1));
   localparam int COORD_MAX = (1 << (COORD_BITS-1)) - 1;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;
   int               mismatches;
   int               pixels_owed;
   int               sent_items;
   int               burst_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   line_rasterizer_unit #(.COORD_BITS(COORD_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   line_rasterizer_checker #(.COORD_BITS(COORD_BITS)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .mismatches(mismatches), .pixels_owed(pixels_owed)
   );

   task automatic send_item(input logic mode, input int sx, input int sy,
                            input int ex, input int ey);
      logic [REQ_W-1:0] d;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      d = '0;
      d[0 +: COORD_BITS]            = sx[COORD_BITS-1:0];
      d[COORD_BITS +: COORD_BITS]   = sy[COORD_BITS-1:0];
      d[2*COORD_BITS +: COORD_BITS] = ex[COORD_BITS-1:0];
      d[3*COORD_BITS +: COORD_BITS] = ey[COORD_BITS-1:0];
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   // Advance requests carry random coordinates, which the block must ignore.
   task automatic send_advance();
      send_item(lr_pkg::MODE_ADVANCE, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input int steps);
      send_item(lr_pkg::MODE_START, sx, sy, ex, ey);
      repeat (steps) send_advance();
   endtask

   function automatic int near_coord(input int v);
      int off;
      off = $urandom_range(0, 24) - 12;
      return (v + off > COORD_MAX || v + off < COORD_MIN) ? v - off : v + off;
   endfunction

   function automatic int rand_coord();
      return $urandom_range(0, COORD_MAX - COORD_MIN) + COORD_MIN;
   endfunction

   initial begin
      int sx, sy, ex, ey, ax, ay, n, kind, tail;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = lr_pkg::MODE_START;
      req_tdata  = '0;
      sent_items = 0;
      burst_left = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_advance();
      draw_line(0, 0, 0, 0, 1);
      draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 3);
      draw_line(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1);
      draw_line(5, 5, 2, 5, 4);
      draw_line(0, -3, 0, 1, 4);
      draw_line(0, 0, 1, -3, 3);
      draw_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1);

      while (sent_items < 1650) begin
         kind = $urandom_range(0, 15);
         if (kind <= 10) begin
            sx = rand_coord();
            sy = rand_coord();
            ex = near_coord(sx);
            ey = near_coord(sy);
            ax = (ex > sx) ? ex - sx : sx - ex;
            ay = (ey > sy) ? ey - sy : sy - ey;
            n  = (ax > ay) ? ax : ay;
            tail = $urandom_range(0, 9);
            if (tail == 0)
               n = n + 1 + $urandom_range(0, 2);
            else if (tail == 1)
               n = $urandom_range(0, n);
            draw_line(sx, sy, ex, ey, n);
         end else if (kind <= 12) begin
            draw_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      $urandom_range(0, 30));
         end else begin
            repeat ($urandom_range(1, 3)) send_advance();
         end
      end

      req_tvalid <= 1'b0;
      while (pixels_owed != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("line_rasterizer_unit test passed");
      else
         $display("line_rasterizer_unit test failed");
      $finish;
   end

   initial begin
      int cycle, hold_left, phase_left, ready_pct;
      rsp_tready = 1'b0;
      cycle      = 0;
      hold_left  = 0;
      phase_left = 0;
      ready_pct  = 100;
      forever begin
         @(negedge clock);
         cycle++;
         if (cycle == 400 || cycle == 2500)
            hold_left = 80;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 50;
                  2: ready_pct = 20;
                  default: ready_pct = 85;
               endcase
               phase_left = $urandom_range(8, 64);
            end
            phase_left--;
            rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
         end
      end
   end

   initial begin
      #400000;
      $display("line_rasterizer_unit test failed");
      $finish;
   end

endmodule
